[hw/rtl/cci_pkg.sv]
// Shared types and constants for the circle-circle intersection core.
// Holds the port word structs, the point-count codes and the side-band records.
// No dependencies.
`default_nettype none

package cci_pkg;

  localparam int unsigned KW = 128;  // radicand width
  localparam int unsigned HW = 64;   // square root width
  localparam int unsigned DW = 65;   // divisor width (2 * d^2)
  localparam int unsigned NW = 97;   // dividend width
  localparam int unsigned QW = 33;   // quotient bits produced before rounding
  localparam int unsigned NL = 4;    // divider lanes: ox, oy, hx, hy

  localparam int unsigned LANE_OX = 0;
  localparam int unsigned LANE_OY = 1;
  localparam int unsigned LANE_HX = 2;
  localparam int unsigned LANE_HY = 3;

  typedef enum logic [1:0] {
    CNT_NONE = 2'd0,
    CNT_ONE  = 2'd1,
    CNT_TWO  = 2'd2
  } cci_count_e;

  typedef struct packed {
    logic signed [31:0] center_a_x;
    logic signed [31:0] center_a_y;
    logic        [30:0] radius_a;
    logic signed [31:0] center_b_x;
    logic signed [31:0] center_b_y;
    logic        [30:0] radius_b;
  } cci_in_t;

  typedef struct packed {
    logic        [1:0]  point_count;
    logic signed [31:0] first_x;
    logic signed [31:0] first_y;
    logic signed [31:0] second_x;
    logic signed [31:0] second_y;
  } cci_out_t;

  // Carried alongside the square root.
  typedef struct packed {
    cci_count_e         count;
    logic signed [31:0] ax;
    logic signed [31:0] ay;
    logic        [31:0] ux;
    logic        [31:0] uy;
    logic               neg_x;
    logic               neg_y;
    logic               neg_n;
    logic        [64:0] mag_n;
    logic        [DW-1:0] den;
  } cci_side_t;

  // Carried alongside the divider.
  typedef struct packed {
    cci_count_e         count;
    logic signed [31:0] ax;
    logic signed [31:0] ay;
    logic [NL-1:0]      neg;
  } cci_tail_t;

endpackage

`default_nettype wire

[hw/rtl/cci_front.sv]
// Front end: centre distance, point count, N = r0^2 + d^2 - r1^2 and the radicand K.
// Six register stages, one 32x32 multiplier deep at most. Uses cci_pkg.
`default_nettype none

module cci_front import cci_pkg::*; (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           vld_i,
  input  cci_in_t        in_i,
  output logic           vld_o,
  output logic [KW-1:0]  rad_o,
  output cci_side_t      side_o
);

  // stage 1
  logic               v1_q;
  logic signed [31:0] ax1_q, ay1_q;
  logic [31:0]        ux1_q, uy1_q, sumr1_q;
  logic               nx1_q, ny1_q;
  logic [30:0]        difr1_q, r0_1_q, r1_1_q;

  logic signed [32:0] dx_w, dy_w;
  logic [32:0]        ux_w, uy_w;

  assign dx_w = {in_i.center_b_x[31], in_i.center_b_x} - {in_i.center_a_x[31], in_i.center_a_x};
  assign dy_w = {in_i.center_b_y[31], in_i.center_b_y} - {in_i.center_a_y[31], in_i.center_a_y};
  assign ux_w = dx_w[32] ? 33'(-dx_w) : 33'(dx_w);
  assign uy_w = dy_w[32] ? 33'(-dy_w) : 33'(dy_w);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
    end else begin
      v1_q <= vld_i;
    end
  end

  always_ff @(posedge clk_i) begin
    ax1_q   <= in_i.center_a_x;
    ay1_q   <= in_i.center_a_y;
    ux1_q   <= ux_w[31:0];
    uy1_q   <= uy_w[31:0];
    nx1_q   <= dx_w[32];
    ny1_q   <= dy_w[32];
    sumr1_q <= {1'b0, in_i.radius_a} + {1'b0, in_i.radius_b};
    difr1_q <= (in_i.radius_a > in_i.radius_b) ? in_i.radius_a - in_i.radius_b
                                               : in_i.radius_b - in_i.radius_a;
    r0_1_q  <= in_i.radius_a;
    r1_1_q  <= in_i.radius_b;
  end

  // stage 2: squares
  logic               v2_q;
  logic signed [31:0] ax2_q, ay2_q;
  logic [31:0]        ux2_q, uy2_q;
  logic               nx2_q, ny2_q;
  logic [63:0]        dx2_q, dy2_q, sout2_q;
  logic [61:0]        tin2_q, r0sq2_q, r1sq2_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v2_q <= 1'b0;
    end else begin
      v2_q <= v1_q;
    end
  end

  always_ff @(posedge clk_i) begin
    ax2_q   <= ax1_q;
    ay2_q   <= ay1_q;
    ux2_q   <= ux1_q;
    uy2_q   <= uy1_q;
    nx2_q   <= nx1_q;
    ny2_q   <= ny1_q;
    dx2_q   <= ux1_q * ux1_q;
    dy2_q   <= uy1_q * uy1_q;
    sout2_q <= sumr1_q * sumr1_q;
    tin2_q  <= difr1_q * difr1_q;
    r0sq2_q <= r0_1_q * r0_1_q;
    r1sq2_q <= r1_1_q * r1_1_q;
  end

  // stage 3: d^2, bit 64 flags a carry
  logic               v3_q;
  logic signed [31:0] ax3_q, ay3_q;
  logic [31:0]        ux3_q, uy3_q;
  logic               nx3_q, ny3_q;
  logic [64:0]        d2_3_q;
  logic [63:0]        sout3_q;
  logic [61:0]        tin3_q, r0sq3_q, r1sq3_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v3_q <= 1'b0;
    end else begin
      v3_q <= v2_q;
    end
  end

  always_ff @(posedge clk_i) begin
    ax3_q   <= ax2_q;
    ay3_q   <= ay2_q;
    ux3_q   <= ux2_q;
    uy3_q   <= uy2_q;
    nx3_q   <= nx2_q;
    ny3_q   <= ny2_q;
    d2_3_q  <= {1'b0, dx2_q} + {1'b0, dy2_q};
    sout3_q <= sout2_q;
    tin3_q  <= tin2_q;
    r0sq3_q <= r0sq2_q;
    r1sq3_q <= r1sq2_q;
  end

  // stage 4: count, K factors, N magnitude and sign
  logic        v4_q;
  cci_side_t   side4_q;
  logic [63:0] ka4_q, kb4_q;

  cci_count_e  cnt_w;
  logic [63:0] d2lo_w, tin64_w;
  logic [64:0] p_w, r1sq65_w;
  cci_side_t   side4_d;

  assign d2lo_w   = d2_3_q[63:0];
  assign tin64_w  = {2'b00, tin3_q};
  assign p_w      = {3'b000, r0sq3_q} + {1'b0, d2lo_w};
  assign r1sq65_w = {3'b000, r1sq3_q};

  always_comb begin
    if (d2_3_q[64] || (d2lo_w == '0) || (d2lo_w > sout3_q) || (d2lo_w < tin64_w)) begin
      cnt_w = CNT_NONE;
    end else if ((d2lo_w == sout3_q) || (d2lo_w == tin64_w)) begin
      cnt_w = CNT_ONE;
    end else begin
      cnt_w = CNT_TWO;
    end
    side4_d.count = cnt_w;
    side4_d.ax    = ax3_q;
    side4_d.ay    = ay3_q;
    side4_d.ux    = ux3_q;
    side4_d.uy    = uy3_q;
    side4_d.neg_x = nx3_q;
    side4_d.neg_y = ny3_q;
    side4_d.neg_n = p_w < r1sq65_w;
    side4_d.mag_n = (p_w < r1sq65_w) ? r1sq65_w - p_w : p_w - r1sq65_w;
    side4_d.den   = {d2lo_w, 1'b0};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v4_q <= 1'b0;
    end else begin
      v4_q <= v3_q;
    end
  end

  always_ff @(posedge clk_i) begin
    side4_q <= side4_d;
    ka4_q   <= sout3_q - d2lo_w;
    kb4_q   <= d2lo_w - tin64_w;
  end

  // stage 5: partial products of K
  logic        v5_q;
  cci_side_t   side5_q;
  logic [63:0] pll5_q, plh5_q, phl5_q, phh5_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v5_q <= 1'b0;
    end else begin
      v5_q <= v4_q;
    end
  end

  always_ff @(posedge clk_i) begin
    side5_q <= side4_q;
    pll5_q  <= ka4_q[31:0]  * kb4_q[31:0];
    plh5_q  <= ka4_q[31:0]  * kb4_q[63:32];
    phl5_q  <= ka4_q[63:32] * kb4_q[31:0];
    phh5_q  <= ka4_q[63:32] * kb4_q[63:32];
  end

  // stage 6: sum partial products
  logic            v6_q;
  cci_side_t       side6_q;
  logic [KW-1:0]   rad6_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v6_q <= 1'b0;
    end else begin
      v6_q <= v5_q;
    end
  end

  always_ff @(posedge clk_i) begin
    side6_q <= side5_q;
    rad6_q  <= {phh5_q, 64'h0} + {32'h0, plh5_q, 32'h0} + {32'h0, phl5_q, 32'h0}
             + {64'h0, pll5_q};
  end

  assign vld_o  = v6_q;
  assign rad_o  = rad6_q;
  assign side_o = side6_q;

endmodule

`default_nettype wire

[hw/rtl/cci_isqrt.sv]
// Pipelined integer square root, one result bit per stage (HW stages).
// Carries the side-band record in step with the data. Uses cci_pkg.
`default_nettype none

module cci_isqrt import cci_pkg::*; (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           vld_i,
  input  logic [KW-1:0]  rad_i,
  input  cci_side_t      side_i,
  output logic           vld_o,
  output logic [HW-1:0]  root_o,
  output cci_side_t      side_o
);

  localparam int unsigned N = HW;

  logic            vld_q  [1:N];
  logic [HW-1:0]   root_q [1:N];
  cci_side_t       side_q [1:N];
  logic [KW-1:0]   rad_q  [1:N-1];
  logic [HW+1:0]   rem_q  [1:N-1];

  for (genvar s = 0; s < N; s++) begin : g_stg
    logic          v_in;
    logic [KW-1:0] x_in;
    logic [HW+1:0] r_in;
    logic [HW-1:0] root_in;
    cci_side_t     s_in;
    logic [HW+3:0] acc, trial;
    logic          ge;

    if (s == 0) begin : g_first
      assign v_in    = vld_i;
      assign x_in    = rad_i;
      assign r_in    = '0;
      assign root_in = '0;
      assign s_in    = side_i;
    end else begin : g_next
      assign v_in    = vld_q[s];
      assign x_in    = rad_q[s];
      assign r_in    = rem_q[s];
      assign root_in = root_q[s];
      assign s_in    = side_q[s];
    end

    assign acc   = {r_in, x_in[KW-1 -: 2]};
    assign trial = {2'b00, root_in, 2'b01};
    assign ge    = acc >= trial;

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vld_q[s+1] <= 1'b0;
      end else begin
        vld_q[s+1] <= v_in;
      end
    end

    always_ff @(posedge clk_i) begin
      root_q[s+1] <= {root_in[HW-2:0], ge};
      side_q[s+1] <= s_in;
    end

    if (s < N - 1) begin : g_carry
      logic [HW+3:0] diff;

      assign diff = acc - trial;

      always_ff @(posedge clk_i) begin
        rad_q[s+1] <= {x_in[KW-3:0], 2'b00};
        rem_q[s+1] <= ge ? diff[HW+1:0] : acc[HW+1:0];
      end
    end
  end

  assign vld_o  = vld_q[N];
  assign root_o = root_q[N];
  assign side_o = side_q[N];

endmodule

`default_nettype wire

[hw/rtl/cci_div.sv]
// Four-lane pipelined restoring divider sharing one divisor, one quotient bit
// per stage, then a rounding stage (ties away from zero). Uses cci_pkg.
`default_nettype none

module cci_div import cci_pkg::*; (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  vld_i,
  input  logic [NL-1:0][NW-1:0] num_i,
  input  logic [DW-1:0]         den_i,
  input  cci_tail_t             tail_i,
  output logic                  vld_o,
  output logic [NL-1:0][QW:0]   quo_o,
  output cci_tail_t             tail_o
);

  logic                  vld_q  [1:QW];
  logic [DW-1:0]         den_q  [1:QW];
  cci_tail_t             tail_q [1:QW];
  logic [NL-1:0][DW-1:0] rem_q  [1:QW];
  logic [NL-1:0][QW-1:0] quo_q  [1:QW];
  logic [NL-1:0][QW-1:0] lo_q   [1:QW-1];

  for (genvar s = 0; s < QW; s++) begin : g_stg
    logic                  v_in;
    logic [DW-1:0]         d_in;
    cci_tail_t             t_in;
    logic [NL-1:0][DW-1:0] r_in;
    logic [NL-1:0][QW-1:0] q_in, lo_in;

    if (s == 0) begin : g_first
      assign v_in = vld_i;
      assign d_in = den_i;
      assign t_in = tail_i;
      for (genvar l = 0; l < NL; l++) begin : g_ln
        assign r_in[l]  = {1'b0, num_i[l][NW-1:QW]};
        assign lo_in[l] = num_i[l][QW-1:0];
        assign q_in[l]  = '0;
      end
    end else begin : g_next
      assign v_in  = vld_q[s];
      assign d_in  = den_q[s];
      assign t_in  = tail_q[s];
      assign r_in  = rem_q[s];
      assign q_in  = quo_q[s];
      assign lo_in = lo_q[s];
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vld_q[s+1] <= 1'b0;
      end else begin
        vld_q[s+1] <= v_in;
      end
    end

    always_ff @(posedge clk_i) begin
      den_q[s+1]  <= d_in;
      tail_q[s+1] <= t_in;
    end

    for (genvar l = 0; l < NL; l++) begin : g_lane
      logic [DW:0] acc, diff;
      logic        ge;

      assign acc  = {r_in[l], lo_in[l][QW-1]};
      assign ge   = acc >= {1'b0, d_in};
      assign diff = acc - {1'b0, d_in};

      always_ff @(posedge clk_i) begin
        rem_q[s+1][l] <= ge ? diff[DW-1:0] : acc[DW-1:0];
        quo_q[s+1][l] <= {q_in[l][QW-2:0], ge};
      end

      if (s < QW - 1) begin : g_shift
        always_ff @(posedge clk_i) begin
          lo_q[s+1][l] <= {lo_in[l][QW-2:0], 1'b0};
        end
      end
    end
  end

  // rounding stage
  logic                  vr_q;
  cci_tail_t             tr_q;
  logic [NL-1:0][QW:0]   qr_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vr_q <= 1'b0;
    end else begin
      vr_q <= vld_q[QW];
    end
  end

  always_ff @(posedge clk_i) begin
    tr_q <= tail_q[QW];
    for (int l = 0; l < NL; l++) begin
      qr_q[l] <= {1'b0, quo_q[QW][l]}
               + (QW+1)'({rem_q[QW][l], 1'b0} >= {1'b0, den_q[QW]});
    end
  end

  assign vld_o  = vr_q;
  assign quo_o  = qr_q;
  assign tail_o = tr_q;

endmodule

`default_nettype wire

[hw/rtl/circle_circle_intersection_core.sv]
// Circle-circle intersection core: count and both points of two Q16.16 circles.
// Accepts one word per cycle.
// Depth is set by the 64-stage square root and the 33-step divider (plus rounding).
// busy stays low: every cycle takes a new word; done_o marks each result for one cycle.
// Reset clears the valid bits only; data registers are not reset.
// Uses cci_pkg, cci_front, cci_isqrt and cci_div.
`default_nettype none

module circle_circle_intersection_core import cci_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     start,
  output logic     busy,
  input  cci_in_t  in_i,
  output logic     done_o,
  output cci_out_t res_o
);

  function automatic logic signed [31:0] sat32(input logic signed [36:0] v);
    logic signed [31:0] r;
    if (v > 37'sd2147483647) begin
      r = 32'sh7fffffff;
    end else if (v < -37'sd2147483648) begin
      r = 32'sh80000000;
    end else begin
      r = v[31:0];
    end
    return r;
  endfunction

  assign busy = 1'b0;

  logic          fv;
  logic [KW-1:0] frad;
  cci_side_t     fside;

  cci_front u_front (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .vld_i  (start),
    .in_i   (in_i),
    .vld_o  (fv),
    .rad_o  (frad),
    .side_o (fside)
  );

  logic          sv;
  logic [HW-1:0] hq;
  cci_side_t     sside;

  cci_isqrt u_isqrt (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .vld_i  (fv),
    .rad_i  (frad),
    .side_i (fside),
    .vld_o  (sv),
    .root_o (hq),
    .side_o (sside)
  );

  // partial products of N*u and hq*u
  logic          m1v_q;
  cci_tail_t     m1tail_q;
  logic [DW-1:0] m1den_q;
  logic [63:0]   nlx_q, nly_q, hlx_q, hly_q, hhx_q, hhy_q;
  logic [64:0]   nhx_q, nhy_q;
  cci_tail_t     tail_d;

  always_comb begin
    tail_d.count        = sside.count;
    tail_d.ax           = sside.ax;
    tail_d.ay           = sside.ay;
    tail_d.neg[LANE_OX] = sside.neg_n ^ sside.neg_x;
    tail_d.neg[LANE_OY] = sside.neg_n ^ sside.neg_y;
    tail_d.neg[LANE_HX] = sside.neg_x;
    tail_d.neg[LANE_HY] = sside.neg_y;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m1v_q <= 1'b0;
    end else begin
      m1v_q <= sv;
    end
  end

  always_ff @(posedge clk_i) begin
    m1tail_q <= tail_d;
    m1den_q  <= sside.den;
    nlx_q    <= sside.mag_n[31:0] * sside.ux;
    nly_q    <= sside.mag_n[31:0] * sside.uy;
    nhx_q    <= sside.mag_n[64:32] * sside.ux;
    nhy_q    <= sside.mag_n[64:32] * sside.uy;
    hlx_q    <= hq[31:0] * sside.ux;
    hly_q    <= hq[31:0] * sside.uy;
    hhx_q    <= hq[63:32] * sside.ux;
    hhy_q    <= hq[63:32] * sside.uy;
  end

  // assemble dividends
  logic                  m2v_q;
  cci_tail_t             m2tail_q;
  logic [DW-1:0]         m2den_q;
  logic [NL-1:0][NW-1:0] num_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m2v_q <= 1'b0;
    end else begin
      m2v_q <= m1v_q;
    end
  end

  always_ff @(posedge clk_i) begin
    m2tail_q        <= m1tail_q;
    m2den_q         <= m1den_q;
    num_q[LANE_OX]  <= {nhx_q, 32'h0} + {33'h0, nlx_q};
    num_q[LANE_OY]  <= {nhy_q, 32'h0} + {33'h0, nly_q};
    num_q[LANE_HX]  <= {1'b0, hhx_q, 32'h0} + {33'h0, hlx_q};
    num_q[LANE_HY]  <= {1'b0, hhy_q, 32'h0} + {33'h0, hly_q};
  end

  logic                dv;
  logic [NL-1:0][QW:0] quo;
  cci_tail_t           dtail;

  cci_div u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .vld_i  (m2v_q),
    .num_i  (num_q),
    .den_i  (m2den_q),
    .tail_i (m2tail_q),
    .vld_o  (dv),
    .quo_o  (quo),
    .tail_o (dtail)
  );

  // signed terms, final sums and saturation
  logic signed [QW+1:0] term [NL];
  logic signed [36:0]   ax37, ay37, fx, fy, sx, sy;
  cci_out_t             res_d;

  always_comb begin
    for (int l = 0; l < NL; l++) begin
      term[l] = dtail.neg[l] ? -$signed({1'b0, quo[l]}) : $signed({1'b0, quo[l]});
    end
    ax37 = 37'(dtail.ax);
    ay37 = 37'(dtail.ay);
    fx = ax37 + 37'(term[LANE_OX]) - 37'(term[LANE_HY]);
    fy = ay37 + 37'(term[LANE_OY]) + 37'(term[LANE_HX]);
    sx = ax37 + 37'(term[LANE_OX]) + 37'(term[LANE_HY]);
    sy = ay37 + 37'(term[LANE_OY]) - 37'(term[LANE_HX]);
    res_d.point_count = dtail.count;
    if (dtail.count == CNT_NONE) begin
      res_d.first_x  = '0;
      res_d.first_y  = '0;
      res_d.second_x = '0;
      res_d.second_y = '0;
    end else begin
      res_d.first_x  = sat32(fx);
      res_d.first_y  = sat32(fy);
      res_d.second_x = sat32(sx);
      res_d.second_y = sat32(sy);
    end
  end

  logic     done_q;
  cci_out_t res_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      done_q <= 1'b0;
    end else begin
      done_q <= dv;
    end
  end

  always_ff @(posedge clk_i) begin
    res_q <= res_d;
  end

  assign done_o = done_q;
  assign res_o  = res_q;

endmodule

`default_nettype wire

[tb/tb_top.sv]
// Self-checking testbench for circle_circle_intersection_core.
// Uses cci_pkg; predicts count and points per input word and checks each done_o word.
`timescale 1ns / 1ps

module tb_top;
  import cci_pkg::*;

  typedef struct {
    cci_in_t word;
    bit      drain;
  } pend_t;

  logic     clk_i = 1'b0;
  logic     rst_ni = 1'b0;
  logic     start = 1'b0;
  logic     busy;
  cci_in_t  in_i = '0;
  logic     done_o;
  cci_out_t res_o;

  pend_t    pending_words[$];
  cci_out_t expected_points[$];
  int       gap_left = 0;
  int       words_sent = 0;
  int       words_checked = 0;
  int       mismatches = 0;
  int       seen_count[3] = '{0, 0, 0};
  bit       no_idle = 1'b0;

  circle_circle_intersection_core dut (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .start (start),
    .busy  (busy),
    .in_i  (in_i),
    .done_o(done_o),
    .res_o (res_o)
  );

  always #1 clk_i = ~clk_i;

  initial begin
    #2_000_000;
    $display("FAILURE");
    $finish;
  end

  function automatic logic signed [71:0] apply_sign(logic [131:0] mag, bit neg);
    logic signed [71:0] t;
    t = signed'(mag[71:0]);
    return neg ? -t : t;
  endfunction

  function automatic logic [31:0] clamp32(logic signed [71:0] v);
    if (v > 72'sd2147483647) return 32'h7fff_ffff;
    if (v < -72'sd2147483648) return 32'h8000_0000;
    return v[31:0];
  endfunction

  // round(mag * v / den), ties away from zero, on magnitudes
  function automatic logic [131:0] round_quot(logic [131:0] mag, logic [131:0] v,
                                              logic [131:0] den);
    return (2 * mag * v + den) / (2 * den);
  endfunction

  function automatic cci_out_t predict_points(cci_in_t w);
    logic signed [33:0] dx, dy;
    logic [131:0] ux, uy, d2, r0, r1, sr, dr, s_out, t_in, den, p, q, mag_n, k, hq, c;
    logic signed [71:0] ax, ay, ox, oy, hx, hy;
    bit neg_n;
    cci_out_t r;
    r = '0;
    dx = 34'(w.center_b_x) - 34'(w.center_a_x);
    dy = 34'(w.center_b_y) - 34'(w.center_a_y);
    ux = dx < 0 ? 132'(-dx) : 132'(dx);
    uy = dy < 0 ? 132'(-dy) : 132'(dy);
    d2 = ux * ux + uy * uy;
    r0 = 132'(w.radius_a);
    r1 = 132'(w.radius_b);
    sr = r0 + r1;
    dr = r0 > r1 ? r0 - r1 : r1 - r0;
    s_out = sr * sr;
    t_in = dr * dr;
    if (d2 == 0 || d2 > s_out || d2 < t_in) return r;
    r.point_count = (d2 == s_out || d2 == t_in) ? CNT_ONE : CNT_TWO;
    den = 2 * d2;
    p = r0 * r0 + d2;
    q = r1 * r1;
    neg_n = p < q;
    mag_n = neg_n ? q - p : p - q;
    k = (s_out - d2) * (d2 - t_in);
    hq = 0;
    for (int b = 63; b >= 0; b--) begin
      c = hq | (132'd1 << b);
      if (c * c <= k) hq = c;
    end
    ax = 72'(w.center_a_x);
    ay = 72'(w.center_a_y);
    ox = apply_sign(round_quot(mag_n, ux, den), neg_n != (dx < 0));
    oy = apply_sign(round_quot(mag_n, uy, den), neg_n != (dy < 0));
    hx = apply_sign(round_quot(hq, ux, den), dx < 0);
    hy = apply_sign(round_quot(hq, uy, den), dy < 0);
    r.first_x  = clamp32(ax + ox - hy);
    r.first_y  = clamp32(ay + oy + hx);
    r.second_x = clamp32(ax + ox + hy);
    r.second_y = clamp32(ay + oy - hx);
    return r;
  endfunction

  function automatic int pick_gap();
    int sel;
    sel = $urandom_range(0, 19);
    if (no_idle || sel < 12) return 0;
    if (sel < 18) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // Driver: present words from the pending queue, hold for drain markers.
  always @(posedge clk_i or negedge rst_ni) begin : drv_proc
    pend_t nxt;
    if (!rst_ni) begin
      start <= 1'b0;
      in_i <= '0;
      gap_left <= 0;
    end else begin
      if (start && !busy) begin
        expected_points.push_back(predict_points(in_i));
        words_sent++;
      end
      if (start && busy) begin
        // hold the current word
      end else if (gap_left > 0) begin
        gap_left <= gap_left - 1;
        start <= 1'b0;
      end else if (pending_words.size() > 0 &&
                   !(pending_words[0].drain && expected_points.size() > 0)) begin
        nxt = pending_words.pop_front();
        in_i <= nxt.word;
        start <= 1'b1;
        gap_left <= pick_gap();
      end else begin
        start <= 1'b0;
      end
    end
  end

  // Monitor: compare each done_o word with the oldest expectation.
  always @(posedge clk_i) begin : mon_proc
    cci_out_t exp_w;
    if (rst_ni && done_o) begin
      if (expected_points.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result word %p", res_o);
      end else begin
        exp_w = expected_points.pop_front();
        words_checked++;
        if (exp_w.point_count < 3) seen_count[exp_w.point_count]++;
        if (res_o.point_count !== exp_w.point_count || res_o.first_x !== exp_w.first_x ||
            res_o.first_y !== exp_w.first_y || res_o.second_x !== exp_w.second_x ||
            res_o.second_y !== exp_w.second_y) begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch on word %0d: expected %p, got %p", words_checked, exp_w, res_o);
        end
      end
    end
  end

  // radii arrive as 32-bit values; keep the low 31 bits
  task automatic queue_word(logic [31:0] ax, logic [31:0] ay, logic [31:0] ra,
                            logic [31:0] bx, logic [31:0] by, logic [31:0] rb,
                            bit drain = 1'b0);
    pend_t e;
    e.word = '{center_a_x: ax, center_a_y: ay, radius_a: ra[30:0],
               center_b_x: bx, center_b_y: by, radius_b: rb[30:0]};
    e.drain = drain;
    pending_words.push_back(e);
  endtask

  function automatic logic [31:0] rand_coord(int bits);
    logic signed [31:0] v;
    v = $urandom;
    return v >>> (32 - bits);
  endfunction

  task automatic queue_random(bit drain);
    int s, sel;
    logic [31:0] ax, ay, dx, dy;
    logic [31:0] r0, r1;
    sel = $urandom_range(0, 9);
    s = $urandom_range(3, 30);
    ax = rand_coord(32);
    ay = rand_coord(32);
    dx = rand_coord(s);
    dy = rand_coord(s);
    r0 = $urandom_range(0, 2 ** (s - 1));
    r1 = $urandom_range(0, 2 ** (s - 1));
    if (sel < 2) begin
      // noise: every field fully random
      queue_word($urandom, $urandom, $urandom, $urandom, $urandom, $urandom, drain);
    end else if (sel < 4) begin
      // tangent along an axis
      dy = 0;
      if (dx[31]) dx = -dx;
      r0 = $urandom_range(0, dx);
      r1 = $urandom_range(0, 1) ? dx - r0 : dx + r0;
      queue_word(ax, ay, r0, ax + dx, ay, r1, drain);
    end else begin
      queue_word(ax, ay, r0, ax + dx, ay + dy, r1, drain);
    end
  endtask

  initial begin
    localparam logic [31:0] ONE = 32'h0001_0000;
    localparam logic [31:0] CMAX = 32'h7fff_ffff;
    localparam logic [31:0] CMIN = 32'h8000_0000;
    localparam logic [31:0] RMAX = 32'h7fff_ffff;
    // coincident centres, with and without radius
    queue_word(0, 0, ONE, 0, 0, ONE);
    queue_word(0, 0, 0, 0, 0, 0);
    // far apart, and points of zero radius apart
    queue_word(0, 0, ONE, 10 * ONE, 0, ONE);
    queue_word(0, 0, 0, ONE, ONE, 0);
    // outer and inner tangents
    queue_word(0, 0, ONE, 2 * ONE, 0, ONE);
    queue_word(0, 0, 3 * ONE, ONE, 0, 2 * ONE);
    queue_word(-5 * ONE, 7 * ONE, 2 * ONE, -5 * ONE, 10 * ONE, ONE);
    // crossing, including negative a and negative directions
    queue_word(0, 0, ONE, ONE, 0, ONE);
    queue_word(3 * ONE, 2 * ONE, ONE, 2 * ONE, ONE, 2 * ONE);
    queue_word(ONE, -ONE, 5 * ONE, -ONE, ONE, 4 * ONE);
    // one circle inside the other
    queue_word(0, 0, 10 * ONE, ONE, 0, ONE);
    // extremes: distance beyond 64 bits, corner to corner, full radii
    queue_word(CMIN, CMIN, RMAX, CMAX, CMAX, RMAX);
    queue_word(CMIN, 0, RMAX, CMAX, 0, RMAX);
    queue_word(CMAX, CMAX, RMAX, CMAX - 1, CMAX, RMAX);
    queue_word(CMIN, CMIN, RMAX, CMIN + 1, CMIN + 1, RMAX);
    queue_word(CMAX, CMIN, RMAX, CMIN, CMAX, 0);
    queue_word(CMAX, CMAX, 1, CMAX, CMAX - 1, 1);
    queue_word(0, 0, RMAX, 0, 1, RMAX);
    for (int i = 0; i < 750; i++) begin
      if (i % 60 == 0) no_idle = $urandom_range(0, 2) == 0;
      queue_random(i == 0 || i == 400);
    end
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    while (pending_words.size() > 0 || expected_points.size() > 0 || start)
      @(posedge clk_i);
    repeat (150) @(posedge clk_i);
    $display("%0d words sent, %0d checked: %0d disjoint, %0d tangent, %0d crossing",
             words_sent, words_checked, seen_count[0], seen_count[1], seen_count[2]);
    if (mismatches == 0 && expected_points.size() == 0) begin
      $display("SUCCESS");
    end else begin
      $display("%0d mismatches, %0d results missing", mismatches, expected_points.size());
      $display("FAILURE");
    end
    $finish;
  end

endmodule
